### design/adc_to_temperature_table_interp_macros.svh
// Assertion helpers for the checker file.
`ifndef ADC_TO_TEMPERATURE_TABLE_INTERP_MACROS_SVH
`define ADC_TO_TEMPERATURE_TABLE_INTERP_MACROS_SVH

// Checked only while the block is out of reset.
`define ADCTI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("adcti assertion failed");

// Checked on every edge, reset included.
`define ADCTI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("adcti assertion failed");

`endif

### design/adcti_pkg.sv
package adcti_pkg;

  localparam int DATA_W        = 16;
  localparam int PROD_W        = 32;
  localparam int CNT_W         = $clog2(PROD_W);
  localparam int CFG_IDX_W     = 3;
  localparam int TABLE_ENTRIES = 131;
  localparam int ROM_POINTS    = 131;
  localparam int USED_ENTRIES  = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;
  localparam int IDX_W         = $clog2(ROM_POINTS);

  // Highest segment the index may hold, and the last table point.
  localparam logic [IDX_W-1:0] SEG_TOP  = IDX_W'(USED_ENTRIES - 2);
  localparam logic [IDX_W-1:0] SEG_LAST = IDX_W'(USED_ENTRIES - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_HIGH  = 3'd5;

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_RES  = 2'd1;
  localparam logic [1:0] MODE_TEMP = 2'd2;

  localparam logic [1:0] FLAG_IN    = 2'd0;
  localparam logic [1:0] FLAG_BELOW = 2'd1;
  localparam logic [1:0] FLAG_ABOVE = 2'd2;

  localparam logic [DATA_W-1:0] RST_TEMP_LOW  = 16'd3400;
  localparam logic [DATA_W-1:0] RST_TEMP_HIGH = 16'd4400;
  localparam logic [DATA_W-1:0] RST_RES_LOW   = 16'd22333;
  localparam logic [DATA_W-1:0] RST_RES_HIGH  = 16'd33527;

  localparam logic [DATA_W-1:0] TEMP_TAB [ROM_POINTS] = '{
    16'd3400,16'd3410,16'd3420,16'd3430,16'd3440,16'd3450,16'd3460,16'd3470,16'd3480,16'd3490,
    16'd3500,16'd3505,16'd3510,16'd3515,16'd3520,16'd3525,16'd3530,16'd3535,16'd3540,16'd3545,
    16'd3550,16'd3555,16'd3560,16'd3565,16'd3570,16'd3575,16'd3580,16'd3585,16'd3590,16'd3595,
    16'd3600,16'd3605,16'd3610,16'd3615,16'd3620,16'd3625,16'd3630,16'd3635,16'd3640,16'd3645,
    16'd3650,16'd3655,16'd3660,16'd3665,16'd3670,16'd3675,16'd3680,16'd3685,16'd3690,16'd3695,
    16'd3700,16'd3705,16'd3710,16'd3715,16'd3720,16'd3725,16'd3730,16'd3735,16'd3740,16'd3745,
    16'd3750,16'd3755,16'd3760,16'd3765,16'd3770,16'd3775,16'd3780,16'd3785,16'd3790,16'd3795,
    16'd3800,16'd3810,16'd3820,16'd3830,16'd3840,16'd3850,16'd3860,16'd3870,16'd3880,16'd3890,
    16'd3900,16'd3910,16'd3920,16'd3930,16'd3940,16'd3950,16'd3960,16'd3970,16'd3980,16'd3990,
    16'd4000,16'd4010,16'd4020,16'd4030,16'd4040,16'd4050,16'd4060,16'd4070,16'd4080,16'd4090,
    16'd4100,16'd4110,16'd4120,16'd4130,16'd4140,16'd4150,16'd4160,16'd4170,16'd4180,16'd4190,
    16'd4200,16'd4210,16'd4220,16'd4230,16'd4240,16'd4250,16'd4260,16'd4270,16'd4280,16'd4290,
    16'd4300,16'd4310,16'd4320,16'd4330,16'd4340,16'd4350,16'd4360,16'd4370,16'd4380,16'd4390,
    16'd4400
  };

  localparam logic [DATA_W-1:0] RES_TAB [ROM_POINTS] = '{
    16'd33527,16'd33388,16'd33250,16'd33113,16'd32976,16'd32840,16'd32704,16'd32570,
    16'd32435,16'd32302,
    16'd32168,16'd32102,16'd32036,16'd31970,16'd31904,16'd31838,16'd31773,16'd31707,
    16'd31642,16'd31577,
    16'd31512,16'd31447,16'd31382,16'd31318,16'd31253,16'd31189,16'd31125,16'd31061,
    16'd30997,16'd30934,
    16'd30870,16'd30807,16'd30743,16'd30680,16'd30617,16'd30555,16'd30492,16'd30429,
    16'd30367,16'd30305,
    16'd30243,16'd30181,16'd30119,16'd30057,16'd29995,16'd29934,16'd29873,16'd29812,
    16'd29751,16'd29690,
    16'd29629,16'd29568,16'd29508,16'd29448,16'd29387,16'd29327,16'd29267,16'd29208,
    16'd29148,16'd29088,
    16'd29029,16'd28970,16'd28911,16'd28852,16'd28793,16'd28734,16'd28676,16'd28617,
    16'd28559,16'd28501,
    16'd28442,16'd28327,16'd28211,16'd28097,16'd27983,16'd27869,16'd27756,16'd27643,
    16'd27531,16'd27419,
    16'd27308,16'd27197,16'd27087,16'd26977,16'd26868,16'd26759,16'd26651,16'd26543,
    16'd26436,16'd26329,
    16'd26223,16'd26117,16'd26012,16'd25907,16'd25802,16'd25698,16'd25595,16'd25491,
    16'd25389,16'd25287,
    16'd25185,16'd25084,16'd24983,16'd24882,16'd24782,16'd24683,16'd24584,16'd24485,
    16'd24387,16'd24289,
    16'd24192,16'd24095,16'd23999,16'd23903,16'd23807,16'd23712,16'd23617,16'd23523,
    16'd23429,16'd23335,
    16'd23242,16'd23149,16'd23057,16'd22965,16'd22873,16'd22782,16'd22692,16'd22601,
    16'd22511,16'd22422,
    16'd22333
  };

  localparam logic [DATA_W-1:0] ADC_TAB [ROM_POINTS] = '{
    16'd16247,16'd16281,16'd16316,16'd16349,16'd16384,16'd16419,16'd16452,16'd16486,
    16'd16520,16'd16554,
    16'd16588,16'd16605,16'd16621,16'd16639,16'd16655,16'd16671,16'd16689,16'd16706,
    16'd16723,16'd16740,
    16'd16756,16'd16773,16'd16789,16'd16807,16'd16824,16'd16840,16'd16857,16'd16874,
    16'd16891,16'd16907,
    16'd16925,16'd16942,16'd16958,16'd16976,16'd16992,16'd17009,16'd17026,16'd17042,
    16'd17059,16'd17075,
    16'd17092,16'd17110,16'd17127,16'd17144,16'd17161,16'd17177,16'd17194,16'd17211,
    16'd17228,16'd17245,
    16'd17261,16'd17278,16'd17295,16'd17311,16'd17327,16'd17344,16'd17361,16'd17378,
    16'd17394,16'd17411,
    16'd17427,16'd17444,16'd17461,16'd17477,16'd17494,16'd17511,16'd17528,16'd17544,
    16'd17560,16'd17577,
    16'd17594,16'd17627,16'd17660,16'd17693,16'd17726,16'd17759,16'd17793,16'd17825,
    16'd17858,16'd17892,
    16'd17925,16'd17958,16'd17990,16'd18023,16'd18057,16'd18090,16'd18122,16'd18155,
    16'd18188,16'd18221,
    16'd18254,16'd18286,16'd18318,16'd18351,16'd18384,16'd18416,16'd18448,16'd18481,
    16'd18514,16'd18546,
    16'd18579,16'd18612,16'd18644,16'd18677,16'd18709,16'd18741,16'd18773,16'd18806,
    16'd18837,16'd18869,
    16'd18901,16'd18933,16'd18966,16'd18997,16'd19030,16'd19062,16'd19094,16'd19125,
    16'd19158,16'd19189,
    16'd19221,16'd19253,16'd19284,16'd19316,16'd19348,16'd19379,16'd19410,16'd19443,
    16'd19474,16'd19505,
    16'd19536
  };

endpackage

### design/adc_to_temperature_table_interp.sv
// Thermistor ADC sample to raw code, resistance or temperature.
// Input channel: adc_sample with in_valid/in_ready. Output channel: value and
// range_flag with out_valid/out_ready. One result comes out per input transaction.
// Configuration is a plain write port (cfg_en, cfg_index, cfg_data); the user must
// write it only while no transaction is in flight; the block does not enforce it.
// Raw mode and samples outside the table go from the idle state straight to the
// emit state. Inside the table the stored segment index is walked one table
// entry per cycle, by at most 129 entries, then the sample passes segment setup,
// the 16x16 multiply, a span check (a zero span skips the divider), the bit-serial
// divider and the final add.
// in_ready is high only while the sequencer is idle, so one sample is in work
// at a time; the next sample can be taken in the cycle after the previous
// result is registered.
// A finished result sits in the output register; if the receiver
// stalls, the next sample is still taken and its result waits in the
// sequencer until the output register frees.
// Reset (rst, synchronous) restores the register defaults, clears the segment
// index and drops out_valid.
module adc_to_temperature_table_interp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [adcti_pkg::DATA_W-1:0]    adc_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [adcti_pkg::DATA_W-1:0]    value,
  output logic [1:0]                      range_flag,
  input  logic                            cfg_en,
  input  logic [adcti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adcti_pkg::DATA_W-1:0]    cfg_data
);
  import adcti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_DN, S_WALK_UP, S_PREP, S_MULT, S_ADJ, S_DIV, S_FINISH, S_EMIT
  } state_t;

  state_t            state;
  logic [1:0]        mode;
  logic [DATA_W-1:0] cali_offset;
  logic [DATA_W-1:0] temp_low_code;
  logic [DATA_W-1:0] temp_high_code;
  logic [DATA_W-1:0] res_low_code;
  logic [DATA_W-1:0] res_high_code;

  logic [IDX_W-1:0]  seg;
  logic [IDX_W-1:0]  seg_inc;
  logic [DATA_W-1:0] v;
  logic [DATA_W-1:0] v_in;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] off;
  logic [DATA_W-1:0] delta;
  logic [DATA_W-1:0] base;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dividend;
  logic [DATA_W-1:0] result;
  logic [1:0]        flag;
  logic              is_temp;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [DATA_W-1:0] a_lo;
  logic [DATA_W-1:0] a_hi;

  assign in_ready = (state == S_IDLE);
  assign v_in     = adc_sample - cali_offset;
  assign seg_inc  = seg + IDX_W'(1);
  assign a_lo     = ADC_TAB[seg];
  assign a_hi     = ADC_TAB[seg_inc];
  assign is_temp  = (mode == MODE_TEMP);

  // Resistance rounds the quotient up, so bias the numerator by span-1.
  assign dividend  = is_temp ? prod : prod + {{(PROD_W-DATA_W){1'b0}}, span} - PROD_W'(1);
  assign div_start = (state == S_ADJ) && (span != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_TEMP;
      cali_offset    <= '0;
      temp_low_code  <= RST_TEMP_LOW;
      temp_high_code <= RST_TEMP_HIGH;
      res_low_code   <= RST_RES_LOW;
      res_high_code  <= RST_RES_HIGH;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_MODE:      mode           <= cfg_data[1:0];
        CFG_OFFSET:    cali_offset    <= cfg_data;
        CFG_TEMP_LOW:  temp_low_code  <= cfg_data;
        CFG_TEMP_HIGH: temp_high_code <= cfg_data;
        CFG_RES_LOW:   res_low_code   <= cfg_data;
        CFG_RES_HIGH:  res_high_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  adcti_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The emit state decides out_valid on its own.
      if (out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            v <= v_in;
            if (mode != MODE_RES && mode != MODE_TEMP) begin
              result <= v_in;
              flag   <= FLAG_IN;
              state  <= S_EMIT;
            end else if (v_in < ADC_TAB[0]) begin
              seg    <= '0;
              result <= is_temp ? temp_low_code : res_high_code;
              flag   <= FLAG_BELOW;
              state  <= S_EMIT;
            end else if (v_in > ADC_TAB[SEG_LAST]) begin
              seg    <= SEG_TOP;
              result <= is_temp ? temp_high_code : res_low_code;
              flag   <= FLAG_ABOVE;
              state  <= S_EMIT;
            end else begin
              if (seg > SEG_TOP) begin
                seg <= SEG_TOP;
              end
              flag  <= FLAG_IN;
              state <= S_WALK_DN;
            end
          end
        end
        S_WALK_DN: begin
          if (seg != '0 && a_lo > v) begin
            seg <= seg - IDX_W'(1);
          end else begin
            state <= S_WALK_UP;
          end
        end
        S_WALK_UP: begin
          if (seg < SEG_TOP && a_hi < v) begin
            seg <= seg_inc;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          span  <= a_hi - a_lo;
          off   <= v - a_lo;
          delta <= is_temp ? TEMP_TAB[seg_inc] - TEMP_TAB[seg] : RES_TAB[seg] - RES_TAB[seg_inc];
          base  <= is_temp ? TEMP_TAB[seg] : RES_TAB[seg];
          state <= S_MULT;
        end
        S_MULT: begin
          prod  <= {{(PROD_W-DATA_W){1'b0}}, delta} * {{(PROD_W-DATA_W){1'b0}}, off};
          state <= S_ADJ;
        end
        S_ADJ: begin
          // A zero-width segment contributes no fraction.
          if (span == '0) begin
            result <= base;
            state  <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          result <= is_temp ? base + div_quo[DATA_W-1:0] : base - div_quo[DATA_W-1:0];
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            value      <= result;
            range_flag <= flag;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/adcti_divider.sv
module adcti_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [adcti_pkg::PROD_W-1:0] dividend,
  input  logic [adcti_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [adcti_pkg::PROD_W-1:0] quotient
);
  import adcti_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsor;
  logic [DATA_W:0]   trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quotient[PROD_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(PROD_W - 1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsor     <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? DATA_W'(trial - {1'b0, dsor}) : trial[DATA_W-1:0];
        quotient <= {quotient[PROD_W-2:0], fits};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### design/adcti_checker.sv
`include "adc_to_temperature_table_interp_macros.svh"

module adcti_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [adcti_pkg::DATA_W-1:0]    value,
  input logic [1:0]                      range_flag
);
  import adcti_pkg::*;

  // A stalled result keeps its payload.
  `ADCTI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> $stable({out_valid, value, range_flag}))

  // The sequencer is busy in the cycle after it takes a sample.
  `ADCTI_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)

  // The range flag never carries the unused code.
  `ADCTI_ASSERT(a_flag_code, clk, rst, out_valid |-> range_flag != 2'd3)

  // Reset leaves no result pending and the sequencer idle.
  `ADCTI_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid && in_ready)

endmodule

bind adc_to_temperature_table_interp adcti_checker u_adcti_checker (.*);

### dv/adcti_reading_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels, keeps its own copy of the
// registers and of the segment index, and compares every output transaction
// with the oldest predicted reading.
module adcti_reading_checker
  import adcti_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [DATA_W-1:0]    adc_sample,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DATA_W-1:0]    value,
  input  logic [1:0]           range_flag,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [1:0]        flag;
  } reading_t;

  logic [1:0]        mode_q;
  logic [DATA_W-1:0] offset_q;
  logic [DATA_W-1:0] temp_low_q;
  logic [DATA_W-1:0] temp_high_q;
  logic [DATA_W-1:0] res_low_q;
  logic [DATA_W-1:0] res_high_q;
  logic [IDX_W-1:0]  seg_idx;

  reading_t expected_readings[$];

  // Converts one sample and moves the remembered segment as the block does.
  function automatic reading_t predict_reading(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] level;
    reading_t          r;
    int                i;
    int unsigned       span;
    int unsigned       off;
    int unsigned       delta;
    int unsigned       q;
    logic              use_temp;
    level    = raw - offset_q;
    r.value  = level;
    r.flag   = FLAG_IN;
    use_temp = (mode_q == MODE_TEMP);
    if (mode_q == MODE_RES || use_temp) begin
      if (level < ADC_TAB[0]) begin
        seg_idx = '0;
        r.value = use_temp ? temp_low_q : res_high_q;
        r.flag  = FLAG_BELOW;
      end else if (level > ADC_TAB[SEG_LAST]) begin
        seg_idx = SEG_TOP;
        r.value = use_temp ? temp_high_q : res_low_q;
        r.flag  = FLAG_ABOVE;
      end else begin
        i = (seg_idx > SEG_TOP) ? int'(SEG_TOP) : int'(seg_idx);
        while (i > 0 && ADC_TAB[i] > level) i--;
        while (i < int'(SEG_TOP) && ADC_TAB[i+1] < level) i++;
        seg_idx = IDX_W'(i);
        span = ADC_TAB[i+1] - ADC_TAB[i];
        off  = level - ADC_TAB[i];
        if (use_temp) begin
          delta   = TEMP_TAB[i+1] - TEMP_TAB[i];
          q       = (span != 0) ? (delta * off) / span : 0;
          r.value = DATA_W'(TEMP_TAB[i] + q);
        end else begin
          // Resistance falls along the table, so the fraction is rounded up.
          delta   = RES_TAB[i] - RES_TAB[i+1];
          q       = (span != 0) ? (delta * off + span - 1) / span : 0;
          r.value = DATA_W'(RES_TAB[i] - q);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      mode_q      = MODE_TEMP;
      offset_q    = '0;
      temp_low_q  = RST_TEMP_LOW;
      temp_high_q = RST_TEMP_HIGH;
      res_low_q   = RST_RES_LOW;
      res_high_q  = RST_RES_HIGH;
      seg_idx     = '0;
      expected_readings.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_MODE:      mode_q      = cfg_data[1:0];
          CFG_OFFSET:    offset_q    = cfg_data;
          CFG_TEMP_LOW:  temp_low_q  = cfg_data;
          CFG_TEMP_HIGH: temp_high_q = cfg_data;
          CFG_RES_LOW:   res_low_q   = cfg_data;
          CFG_RES_HIGH:  res_high_q  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_readings.push_back(predict_reading(adc_sample));
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: output transaction with nothing expected: value %0d, range_flag %0d",
                   $time, value, range_flag);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (value !== want.value) begin
            $display("%0t: value expected %0d, got %0d", $time, want.value, value);
            mismatches++;
          end
          if (range_flag !== want.flag) begin
            $display("%0t: range_flag expected %0d, got %0d", $time, want.flag, range_flag);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

### dv/adc_to_temperature_table_interp_tb.sv
`timescale 1ns / 100ps

module adc_to_temperature_table_interp_tb;
  import adcti_pkg::*;

  localparam logic [1:0]           MODE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam int                   PHASES        = 8;
  localparam int                   PHASE_ITEMS   = 80;
  localparam int                   RUN_LIMIT_NS  = 10_000_000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    adc_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    value;
  logic [1:0]           range_flag;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int                   fail_count;
  int                   outstanding;
  logic [DATA_W-1:0]    offset_now;
  int                   send_calm;
  int                   take_calm;
  logic [1:0]           phase_modes [PHASES] = '{MODE_TEMP, MODE_RES, MODE_RAW, MODE_TEMP,
                                                 MODE_RES, MODE_SPARE, MODE_TEMP, MODE_RES};

  adc_to_temperature_table_interp i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .range_flag (range_flag),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  adcti_reading_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_sample  (adc_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .range_flag  (range_flag),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly random waits, with occasional stretches of back-to-back traffic.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [DATA_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return DATA_W'($urandom);
  endfunction

  // Calibrated level: mostly inside the table, some on its points and edges.
  function automatic logic [DATA_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return DATA_W'($urandom_range(ADC_TAB[0], ADC_TAB[SEG_LAST]));
    if (r < 70) return DATA_W'(ADC_TAB[$urandom_range(0, SEG_LAST)] + $urandom_range(0, 2) - 1);
    if (r < 74) return DATA_W'(ADC_TAB[0] - $urandom_range(1, 40));
    if (r < 78) return DATA_W'(ADC_TAB[SEG_LAST] + $urandom_range(1, 40));
    return DATA_W'($urandom);
  endfunction

  task automatic send_sample(input logic [DATA_W-1:0] sample);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // The block sees level after it subtracts the offset.
  task automatic send_level(input logic [DATA_W-1:0] level);
    send_sample(level + offset_now);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Waits until every transaction has come back, then rewrites all registers.
  task automatic configure(input logic [1:0] mode, input logic [DATA_W-1:0] offset,
                           input logic [DATA_W-1:0] t_low, input logic [DATA_W-1:0] t_high,
                           input logic [DATA_W-1:0] r_low, input logic [DATA_W-1:0] r_high);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_MODE, {14'($urandom), mode});
    write_reg(CFG_OFFSET, offset);
    write_reg(CFG_TEMP_LOW, t_low);
    write_reg(CFG_TEMP_HIGH, t_high);
    write_reg(CFG_RES_LOW, r_low);
    write_reg(CFG_RES_HIGH, r_high);
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, DATA_W'($urandom));
    cfg_en     <= 1'b0;
    offset_now  = offset;
    @(negedge clk);
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    take_calm = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = pick_wait(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [1:0] mode;
    logic [DATA_W-1:0] offset;
    rst        = 1'b1;
    in_valid   = 1'b0;
    adc_sample = '0;
    cfg_en     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    offset_now = '0;
    send_calm  = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: temperature mode, no offset.
    send_sample('0);
    send_sample('1);
    send_level(DATA_W'(ADC_TAB[0] - 1));
    send_level(ADC_TAB[0]);
    send_level(DATA_W'(ADC_TAB[0] + 1));
    // Full walk up from the bottom segment, then full walk down from the top.
    send_level(ADC_TAB[SEG_LAST]);
    send_level(DATA_W'(ADC_TAB[SEG_LAST] + 1));
    send_level(DATA_W'(ADC_TAB[0] + 1));
    send_level(ADC_TAB[65]);
    send_level(DATA_W'(ADC_TAB[65] + 7));
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    configure(MODE_RES, '0, RST_TEMP_LOW, RST_TEMP_HIGH, RST_RES_LOW, RST_RES_HIGH);
    send_level(DATA_W'(ADC_TAB[0] - 1));
    send_level(DATA_W'(ADC_TAB[SEG_LAST] + 1));
    send_level(ADC_TAB[0]);
    send_level(DATA_W'(ADC_TAB[40] + 3));
    send_level(ADC_TAB[SEG_LAST]);

    // Raw and spare modes must leave the segment index where it was.
    configure(MODE_RAW, 16'h8000, '0, '1, '0, '1);
    send_sample('0);
    send_sample('1);
    configure(MODE_SPARE, 16'h7FFF, '1, '0, '1, '0);
    send_sample(16'h1234);
    configure(MODE_TEMP, '1, '0, '1, '1, '0);
    send_level(DATA_W'(ADC_TAB[SEG_LAST] - 2));
    send_level(DATA_W'(ADC_TAB[0] - 1));
    send_level(DATA_W'(ADC_TAB[SEG_LAST] + 1));

    for (int p = 0; p < PHASES; p++) begin
      mode = phase_modes[p];
      case ($urandom_range(0, 4))
        0:       offset = '0;
        1:       offset = 16'h7FFF;
        2:       offset = 16'h8000;
        3:       offset = '1;
        default: offset = DATA_W'($urandom);
      endcase
      configure(mode, offset, pick_code(), pick_code(), pick_code(), pick_code());
      for (int n = 0; n < PHASE_ITEMS; n++) send_level(pick_level());
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/adcti_pkg.sv
design/adcti_divider.sv
design/adc_to_temperature_table_interp.sv
design/adcti_checker.sv
dv/adcti_reading_checker.sv
dv/adc_to_temperature_table_interp_tb.sv
